>>> sv/pipt_pkg.sv
// ----------------------------------------------------------------------------
// pipt_pkg: shared types and constants of the point-in-polygon test
// Item and result structs, vertex type, opcodes and the cell control group.
// ----------------------------------------------------------------------------
package pipt_pkg;

  localparam int DEF_MAX_VERTICES = 128;

  localparam logic [1:0] OP_NEW    = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } pipt_in_t;

  typedef struct packed {
    logic inside_res;
    logic on_boundary;
  } pipt_out_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } vertex_t;

  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> sv/pipt_cell.sv
// ----------------------------------------------------------------------------
// pipt_cell: one vertex cell of the rotating chain
// Holds one vertex; loads it on a write at its index and, during a walk,
// takes its neighbor's vertex, the last active cell taking the head's.
// ----------------------------------------------------------------------------
module pipt_cell #(
  parameter int IDX_W = 7,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  pipt_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [IDX_W-1:0]     last_idx,
  input  pipt_pkg::vertex_t    wr_vtx,
  input  pipt_pkg::vertex_t    next_vtx,
  input  pipt_pkg::vertex_t    head_vtx,
  output pipt_pkg::vertex_t    vtx
);
  import pipt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.wr && (wr_idx == MY_IDX)) begin
      vtx <= wr_vtx;
    end else if (ctrl.shift && (MY_IDX <= last_idx)) begin
      vtx <= (MY_IDX == last_idx) ? head_vtx : next_vtx;
    end
  end

endmodule

>>> sv/pipt_edge.sv
// ----------------------------------------------------------------------------
// pipt_edge: three-stage edge evaluator
// Takes one edge per cycle, forms cross and dot products against the query
// point and accumulates the boundary hit and the crossing parity.
// ----------------------------------------------------------------------------
module pipt_edge (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              issue,
  input  pipt_pkg::vertex_t q,
  input  pipt_pkg::vertex_t a,
  input  pipt_pkg::vertex_t b,
  output logic              hit,
  output logic              parity
);
  import pipt_pkg::*;

  logic               v0;
  logic               v1;
  logic signed [16:0] ax;
  logic signed [16:0] ay;
  logic signed [16:0] bx;
  logic signed [16:0] by;
  logic signed [33:0] p_axby;
  logic signed [33:0] p_aybx;
  logic signed [33:0] p_axbx;
  logic signed [33:0] p_ayby;
  logic               ay_neg;
  logic               by_neg;
  logic signed [34:0] cr;
  logic signed [34:0] dt;
  logic               hit_c;
  logic               cross_c;

  always_ff @(posedge clk) begin
    ax <= $signed({a.x[15], a.x}) - $signed({q.x[15], q.x});
    ay <= $signed({a.y[15], a.y}) - $signed({q.y[15], q.y});
    bx <= $signed({b.x[15], b.x}) - $signed({q.x[15], q.x});
    by <= $signed({b.y[15], b.y}) - $signed({q.y[15], q.y});
    p_axby <= ax * by;
    p_aybx <= ay * bx;
    p_axbx <= ax * bx;
    p_ayby <= ay * by;
    ay_neg <= ay[16];
    by_neg <= by[16];
  end

  assign cr = $signed({p_axby[33], p_axby}) - $signed({p_aybx[33], p_aybx});
  assign dt = $signed({p_axbx[33], p_axbx}) + $signed({p_ayby[33], p_ayby});
  assign hit_c = (cr == 35'sd0) && (dt[34] || (dt == 35'sd0));
  assign cross_c = (!cr[34] && ay_neg && !by_neg) ||
                   ((cr[34] || (cr == 35'sd0)) && !ay_neg && by_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      v1     <= 1'b0;
      hit    <= 1'b0;
      parity <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      if (clear) begin
        hit    <= 1'b0;
        parity <= 1'b0;
      end else if (v1) begin
        if (hit_c) begin
          hit <= 1'b1;
        end else if (cross_c && !hit) begin
          parity <= ~parity;
        end
      end
    end
  end

endmodule

>>> sv/point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_top: crossing-number point-in-polygon test
// Vertex store as a rotating chain of cells feeding a pipelined edge unit.
// ----------------------------------------------------------------------------
// Vertex items (start new, append) are taken while idle and busy stays low.
// A query holds busy while the vertex chain rotates once, one edge per cycle
// into a three-stage product pipeline that then drains; done pulses for one
// cycle with the result in the last busy cycle. An empty polygon answers in
// the cycle after the query is taken. The result stays until the next query.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = pipt_pkg::DEF_MAX_VERTICES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pipt_pkg::pipt_in_t  item,
  output logic                done,
  output pipt_pkg::pipt_out_t result
);
  import pipt_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] step;
  logic             drain;
  vertex_t          qpt;

  logic             accept;
  logic             room;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] wr_idx;
  cell_ctrl_t       ctrl;
  vertex_t          wr_vtx;
  vertex_t          cell_vtx [MAX_VERTICES];
  vertex_t          edge_b;
  logic             hit;
  logic             parity;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign room     = (count < CNT_W'(MAX_VERTICES));
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign wr_idx   = (item.opcode == OP_NEW) ? '0 : count[IDX_W-1:0];
  assign wr_vtx   = '{x: item.px, y: item.py};
  assign ctrl.wr  = accept && ((item.opcode == OP_NEW) ||
                               ((item.opcode == OP_APPEND) && room));
  assign ctrl.shift = (state == S_WALK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (item.opcode)
              OP_NEW: begin
                count <= CNT_W'(1);
              end
              OP_APPEND: begin
                if (room) begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                qpt   <= wr_vtx;
                step  <= '0;
                state <= (count == '0) ? S_RESULT : S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          step <= step + IDX_W'(1);
          if (step == last_idx) begin
            drain <= 1'b0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    pipt_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_idx   (wr_idx),
      .last_idx (last_idx),
      .wr_vtx   (wr_vtx),
      .next_vtx (cell_vtx[(k + 1) % MAX_VERTICES]),
      .head_vtx (cell_vtx[0]),
      .vtx      (cell_vtx[k])
    );
  end

  assign edge_b = (count == CNT_W'(1)) ? cell_vtx[0] : cell_vtx[1];

  pipt_edge u_edge (
    .clk    (clk),
    .rst    (rst),
    .clear  (accept && (item.opcode == OP_QUERY)),
    .issue  (state == S_WALK),
    .q      (qpt),
    .a      (cell_vtx[0]),
    .b      (edge_b),
    .hit    (hit),
    .parity (parity)
  );

  assign done               = (state == S_RESULT);
  assign result.inside_res  = hit || parity;
  assign result.on_boundary = hit;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_boundary_inside: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.inside_res || !result.on_boundary))
    else $error("boundary result not reported inside");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.opcode == OP_QUERY)) |=> busy)
    else $error("query item accepted without going busy");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (count != '0))
    else $error("walk over an empty polygon");

  a_walk_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (step <= last_idx))
    else $error("walk step beyond last vertex");

endmodule

>>> bench/tb_point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_top: self-checking bench of the point-in-polygon test
// Builds polygons and fires query points at them through the start/busy port.
// A shadow vertex list predicts every query answer by exact crossing count,
// and each done strobe is checked field by field against the oldest answer.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_top;
  import pipt_pkg::*;

  localparam int MAX_V      = DEF_MAX_VERTICES;
  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_ITEMS  = 1200;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    pipt_in_t item;
    int       gap;
    bit       drain;
  } send_slot_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  pipt_in_t  item;
  logic      done;
  pipt_out_t result;

  send_slot_t         pending_items[$];
  pipt_out_t          expected_answers[$];
  send_slot_t         cur;
  bit                 loaded;
  bit                 presenting;
  bit                 item_taken;
  bit                 burst;
  bit                 drain_next;
  int                 items_made;
  int                 errors;
  int                 idle_cycles;
  logic signed [15:0] poly_x[0:MAX_V-1];
  logic signed [15:0] poly_y[0:MAX_V-1];
  int                 poly_count;

  point_in_polygon_test_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pipt_out_t locate_point(input logic signed [15:0] qx,
                                             input logic signed [15:0] qy);
    longint    ax, ay, bx, by, cr, dt;
    int        j;
    int        crossings;
    pipt_out_t r;
    r = '0;
    crossings = 0;
    for (int i = 0; i < poly_count && !r.on_boundary; i++) begin
      j  = (i + 1 < poly_count) ? i + 1 : 0;
      ax = longint'(poly_x[i]) - longint'(qx);
      ay = longint'(poly_y[i]) - longint'(qy);
      bx = longint'(poly_x[j]) - longint'(qx);
      by = longint'(poly_y[j]) - longint'(qy);
      cr = ax * by - ay * bx;
      dt = ax * bx + ay * by;
      if (cr == 0 && dt <= 0) begin
        r.on_boundary = 1'b1;
      end else if ((cr >= 0 && ay < 0 && by >= 0) || (cr <= 0 && ay >= 0 && by < 0)) begin
        crossings++;
      end
    end
    r.inside_res = r.on_boundary | crossings[0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_coord(input int span);
    if (span == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic add_item(input logic [1:0] op, input logic signed [15:0] x,
                          input logic signed [15:0] y);
    send_slot_t s;
    s.item.opcode = op;
    s.item.px     = x;
    s.item.py     = y;
    s.gap         = burst ? 0 : int'($urandom_range(0, 13));
    s.drain       = drain_next;
    drain_next    = 1'b0;
    pending_items.push_back(s);
    if (op != OP_SPARE) items_made++;
  endtask

  // driver: present items at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (item_taken) presenting = 1'b0;
      if (!presenting) begin
        if (!loaded && pending_items.size() != 0) begin
          cur    = pending_items.pop_front();
          loaded = 1'b1;
        end
        if (loaded) begin
          if (cur.gap > 0) begin
            cur.gap--;
          end else if (!(cur.drain && (expected_answers.size() != 0 || busy))) begin
            item       <= cur.item;
            presenting = 1'b1;
            loaded     = 1'b0;
          end
        end
      end
      start <= presenting;
    end
  end

  // monitor: check results, then track accepted items
  always @(posedge clk) begin
    pipt_out_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_answers.size() == 0) begin
          $error("result with no query pending: inside_res %0d on_boundary %0d",
                 result.inside_res, result.on_boundary);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (result.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d", want.inside_res, result.inside_res);
            errors++;
          end
          if (result.on_boundary !== want.on_boundary) begin
            $error("on_boundary: expected %0d, got %0d", want.on_boundary,
                   result.on_boundary);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        case (item.opcode)
          OP_NEW: begin
            poly_x[0]  = item.px;
            poly_y[0]  = item.py;
            poly_count = 1;
          end
          OP_APPEND: begin
            if (poly_count < MAX_V) begin
              poly_x[poly_count] = item.px;
              poly_y[poly_count] = item.py;
              poly_count++;
            end
          end
          OP_QUERY: expected_answers.push_back(locate_point(item.px, item.py));
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL point_in_polygon_test_top");
        $finish;
      end
    end
  end

  initial begin
    logic signed [15:0] gx[0:139];
    logic signed [15:0] gy[0:139];
    int                 nv, nq, span, k, k2, mode, big_left;
    bit                 first_poly;

    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    loaded     = 1'b0;
    presenting = 1'b0;
    item_taken = 1'b0;
    burst      = 1'b0;
    drain_next = 1'b0;
    items_made = 0;
    errors     = 0;
    poly_count = 0;
    big_left   = 3;
    first_poly = 1'b1;

    // empty store, append before any start, single vertex, ignored opcode
    add_item(OP_QUERY, 16'sd0, 16'sd0);
    add_item(OP_APPEND, 16'sd5, 16'sd5);
    add_item(OP_QUERY, 16'sd5, 16'sd5);
    add_item(OP_QUERY, 16'sd5, 16'sd6);
    add_item(OP_SPARE, -16'sd1, -16'sd1);
    add_item(OP_QUERY, 16'sd5, 16'sd5);
    // full-range square
    add_item(OP_NEW, -16'sd32768, -16'sd32768);
    add_item(OP_APPEND, 16'sd32767, -16'sd32768);
    add_item(OP_APPEND, 16'sd32767, 16'sd32767);
    add_item(OP_APPEND, -16'sd32768, 16'sd32767);
    add_item(OP_QUERY, 16'sd0, 16'sd0);
    add_item(OP_QUERY, 16'sd32767, 16'sd0);
    add_item(OP_QUERY, -16'sd32768, -16'sd32768);
    add_item(OP_QUERY, -16'sd32768, 16'sd32767);
    add_item(OP_QUERY, 16'sd0, -16'sd32768);
    // degenerate two-vertex polygon
    add_item(OP_NEW, 16'sd0, 16'sd0);
    add_item(OP_APPEND, 16'sd10, 16'sd0);
    add_item(OP_QUERY, 16'sd5, 16'sd0);
    add_item(OP_QUERY, 16'sd5, 16'sd1);
    add_item(OP_QUERY, 16'sd15, 16'sd0);
    // triangle with a horizontal edge
    add_item(OP_NEW, 16'sd0, 16'sd0);
    add_item(OP_APPEND, 16'sd8, 16'sd0);
    add_item(OP_APPEND, 16'sd4, 16'sd8);
    add_item(OP_QUERY, 16'sd4, 16'sd2);
    add_item(OP_QUERY, -16'sd4, 16'sd0);

    while (items_made < NUM_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0);
      drain_next = first_poly || ($urandom_range(0, 7) == 0);
      first_poly = 1'b0;
      case ($urandom_range(0, 3))
        0:       span = 0;
        1:       span = 1000;
        default: span = 8;
      endcase
      if (big_left > 0 && $urandom_range(0, 40) == 0) begin
        nv = $urandom_range(126, 132);
        big_left--;
      end else begin
        nv = $urandom_range(1, 12);
      end
      for (int v = 0; v < nv; v++) begin
        gx[v] = pick_coord(span);
        gy[v] = pick_coord(span);
        if (v == 0 && $urandom_range(0, 9) != 0) add_item(OP_NEW, gx[v], gy[v]);
        else add_item(OP_APPEND, gx[v], gy[v]);
        if ($urandom_range(0, 30) == 0) add_item(OP_SPARE, pick_coord(0), pick_coord(0));
      end
      nq = $urandom_range(2, 8);
      for (int q = 0; q < nq; q++) begin
        k    = $urandom_range(0, nv - 1);
        k2   = (k + 1 < nv) ? k + 1 : 0;
        mode = $urandom_range(0, 5);
        case (mode)
          0: add_item(OP_QUERY, gx[k], gy[k]);
          1: add_item(OP_QUERY, 16'((int'(gx[k]) + int'(gx[k2])) / 2),
                      16'((int'(gy[k]) + int'(gy[k2])) / 2));
          2: add_item(OP_QUERY, 16'(int'(gx[k]) + int'($urandom_range(0, 2)) - 1),
                      16'(int'(gy[k]) + int'($urandom_range(0, 2)) - 1));
          3: add_item(OP_QUERY, pick_coord(0), pick_coord(0));
          default: add_item(OP_QUERY, pick_coord(span), pick_coord(span));
        endcase
        if ($urandom_range(0, 20) == 0) add_item(OP_SPARE, pick_coord(0), pick_coord(0));
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || loaded || presenting) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (MAX_V + 8) @(posedge clk);
    if (expected_answers.size() != 0) errors++;

    if (errors == 0) begin
      $display("PASS point_in_polygon_test_top");
    end else begin
      $display("FAIL point_in_polygon_test_top");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pipt_pkg.sv
sv/pipt_cell.sv
sv/pipt_edge.sv
sv/point_in_polygon_test_top.sv
bench/tb_point_in_polygon_test_top.sv
